// ===== design/ltdp_pkg.sv =====
package ltdp_pkg;

  localparam int unsigned NONTERMINALS = 64;
  localparam int unsigned TERMINALS    = 128;
  localparam int unsigned PRODUCTIONS  = 256;
  localparam int unsigned MAX_RHS      = 8;
  localparam int unsigned STACK_DEPTH  = 64;

  localparam int unsigned TBL_AW = 13;
  localparam int unsigned SYM_AW = 11;
  localparam int unsigned STK_AW = 6;

  localparam logic [7:0]  END_MARK        = 8'd0;
  localparam logic [7:0]  EMPTY_WORD      = 8'd1;
  localparam logic [7:0]  NT_BASE         = 8'd128;
  localparam logic [7:0]  NT_LIMIT        = 8'd192;
  localparam logic [12:0] EXPANSION_LIMIT = 13'd4096;

  localparam logic [1:0] MODE_TABLE   = 2'd0;
  localparam logic [1:0] MODE_SYMBOL  = 2'd1;
  localparam logic [1:0] MODE_TOKEN   = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_CONSUMED = 3'd1;
  localparam logic [2:0] ST_ACCEPT   = 3'd2;
  localparam logic [2:0] ST_REJECT   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_TOP   = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_TBL   = 9'b000010000,
    S_LEN   = 9'b000100000,
    S_PUSH  = 9'b001000000,
    S_PW    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

// ===== design/ll1_table_driven_parser.sv =====
// A load or restart transaction goes from idle straight to the done state, which registers
// its result. A token passes the top and evaluate states for each stack read; an expansion
// adds the table, length and push states and a push-write pair per pushed symbol, and the
// token ends in the done state. The block is idle again once the result is registered, and a
// result that waits for the receiver holds the block. After reset a clearing pass zeroes all
// 8192 parse table entries; no item is accepted meanwhile, configuration is.
module ll1_table_driven_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_start_nonterminal_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [5:0] nonterminal_index_i,
  input  logic [6:0] terminal_code_i,
  input  logic [7:0] production_index_i,
  input  logic       entry_valid_i,
  input  logic [2:0] slot_i,
  input  logic [7:0] symbol_code_i,
  input  logic [3:0] production_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] expansions_o
);

  ltdp_pkg::state_e state_q, state_d;

  logic [5:0]  start_q;
  logic [6:0]  sp_q, sp_d;
  logic [7:0]  e1_q, e1_d;
  logic [6:0]  term_q, term_d;
  logic [7:0]  prod_q, prod_d;
  logic [3:0]  k_q, k_d;
  logic [12:0] exp_q, exp_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  res_q, res_d;
  logic [12:0] clr_q, clr_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  expans_q, expans_d;

  logic [8:0] tbl_mem [2**ltdp_pkg::TBL_AW];
  logic [7:0] sym_mem [2**ltdp_pkg::SYM_AW];
  logic [3:0] len_mem [ltdp_pkg::PRODUCTIONS];
  logic [7:0] stk_mem [ltdp_pkg::STACK_DEPTH];

  logic                        tbl_we;
  logic [ltdp_pkg::TBL_AW-1:0] tbl_wa, tbl_ra;
  logic [8:0]                  tbl_wd, tbl_rd_q;
  logic                        sym_we;
  logic [ltdp_pkg::SYM_AW-1:0] sym_ra;
  logic [7:0]                  sym_rd_q;
  logic [7:0]                  len_ra;
  logic [3:0]                  len_rd_q;
  logic                        stk_we;
  logic [ltdp_pkg::STK_AW-1:0] stk_wa, stk_ra;
  logic [7:0]                  stk_rd_q;

  logic       in_acc;
  logic [6:0] sp_m1;
  logic [7:0] top;
  logic [3:0] len_c;
  logic [7:0] need;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ltdp_pkg::S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign expansions_o = expans_q;

  assign sp_m1  = sp_q - 7'd1;
  // Stack entry 1 lives in a register, entry 0 is always the end marker, and the rest are in the stack memory.
  assign top    = (sp_m1 == 7'd0) ? ltdp_pkg::END_MARK :
                  (sp_m1 == 7'd1) ? e1_q : stk_rd_q;
  assign len_c  = (len_rd_q > 4'(ltdp_pkg::MAX_RHS)) ? 4'(ltdp_pkg::MAX_RHS) : len_rd_q;
  assign need   = {1'b0, sp_m1} + {4'd0, len_c};

  assign stk_ra = sp_m1[ltdp_pkg::STK_AW-1:0];
  assign tbl_ra = {top[5:0], term_q};
  assign len_ra = tbl_rd_q[7:0];
  assign sym_ra = {prod_q, 3'(k_q - 4'd1)};
  assign stk_wa = sp_q[ltdp_pkg::STK_AW-1:0];
  assign stk_we = (state_q == ltdp_pkg::S_PW) && (sp_q != 7'd1);
  assign sym_we = in_acc && (mode_i == ltdp_pkg::MODE_SYMBOL);

  always_comb begin
    if (state_q == ltdp_pkg::S_CLEAR) begin
      tbl_we = 1'b1;
      tbl_wa = clr_q;
      tbl_wd = 9'd0;
    end else begin
      tbl_we = in_acc && (mode_i == ltdp_pkg::MODE_TABLE);
      tbl_wa = {nonterminal_index_i, terminal_code_i};
      tbl_wd = entry_valid_i ? {1'b1, production_index_i} : 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[{production_index_i, slot_i}] <= symbol_code_i;
      len_mem[production_index_i] <= production_length_i;
    end
    sym_rd_q <= sym_mem[sym_ra];
    len_rd_q <= len_mem[len_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= sym_rd_q;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    e1_d        = e1_q;
    term_d      = term_q;
    prod_d      = prod_q;
    k_d         = k_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    expans_d    = expans_q;

    case (state_q)
      ltdp_pkg::S_CLEAR: begin
        clr_d = clr_q + 13'd1;
        if (clr_q == 13'h1fff) begin
          state_d = ltdp_pkg::S_IDLE;
        end
      end
      ltdp_pkg::S_IDLE: begin
        if (in_acc) begin
          term_d = terminal_code_i;
          exp_d  = 13'd0;
          cnt_d  = 8'd0;
          res_d  = ltdp_pkg::ST_LOAD;
          if (mode_i == ltdp_pkg::MODE_TOKEN) begin
            state_d = ltdp_pkg::S_TOP;
          end else begin
            if (mode_i == ltdp_pkg::MODE_RESTART) begin
              sp_d = 7'd2;
              e1_d = ltdp_pkg::NT_BASE | {2'b00, start_q};
            end
            state_d = ltdp_pkg::S_DONE;
          end
        end
      end
      ltdp_pkg::S_TOP: begin
        if (sp_q == 7'd0) begin
          res_d   = ltdp_pkg::ST_REJECT;
          state_d = ltdp_pkg::S_DONE;
        end else begin
          state_d = ltdp_pkg::S_EVAL;
        end
      end
      ltdp_pkg::S_EVAL: begin
        if (top == ltdp_pkg::EMPTY_WORD) begin
          sp_d    = sp_m1;
          state_d = ltdp_pkg::S_TOP;
        end else if (top >= ltdp_pkg::NT_BASE) begin
          if (top >= ltdp_pkg::NT_LIMIT) begin
            res_d   = ltdp_pkg::ST_REJECT;
            state_d = ltdp_pkg::S_DONE;
          end else begin
            state_d = ltdp_pkg::S_TBL;
          end
        end else if (top != {1'b0, term_q}) begin
          res_d   = ltdp_pkg::ST_REJECT;
          state_d = ltdp_pkg::S_DONE;
        end else if ({1'b0, term_q} == ltdp_pkg::END_MARK) begin
          res_d   = (sp_q == 7'd1) ? ltdp_pkg::ST_ACCEPT : ltdp_pkg::ST_REJECT;
          state_d = ltdp_pkg::S_DONE;
        end else begin
          sp_d    = sp_m1;
          res_d   = ltdp_pkg::ST_CONSUMED;
          state_d = ltdp_pkg::S_DONE;
        end
      end
      ltdp_pkg::S_TBL: begin
        if (!tbl_rd_q[8] || (exp_q >= ltdp_pkg::EXPANSION_LIMIT)) begin
          res_d   = ltdp_pkg::ST_REJECT;
          state_d = ltdp_pkg::S_DONE;
        end else begin
          prod_d  = tbl_rd_q[7:0];
          state_d = ltdp_pkg::S_LEN;
        end
      end
      ltdp_pkg::S_LEN: begin
        if (need > 8'(ltdp_pkg::STACK_DEPTH)) begin
          res_d   = ltdp_pkg::ST_OVERFLOW;
          state_d = ltdp_pkg::S_DONE;
        end else begin
          sp_d    = sp_m1;
          k_d     = len_c;
          state_d = ltdp_pkg::S_PUSH;
        end
      end
      ltdp_pkg::S_PUSH: begin
        if (k_q == 4'd0) begin
          exp_d   = exp_q + 13'd1;
          cnt_d   = (cnt_q == 8'd255) ? cnt_q : cnt_q + 8'd1;
          state_d = ltdp_pkg::S_TOP;
        end else begin
          state_d = ltdp_pkg::S_PW;
        end
      end
      ltdp_pkg::S_PW: begin
        if (sp_q == 7'd1) begin
          e1_d = sym_rd_q;
        end
        sp_d    = sp_q + 7'd1;
        k_d     = k_q - 4'd1;
        state_d = ltdp_pkg::S_PUSH;
      end
      ltdp_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          expans_d    = cnt_q;
          if ((res_q == ltdp_pkg::ST_ACCEPT) || (res_q == ltdp_pkg::ST_REJECT) ||
              (res_q == ltdp_pkg::ST_OVERFLOW)) begin
            sp_d = 7'd2;
            e1_d = ltdp_pkg::NT_BASE | {2'b00, start_q};
          end
          state_d = ltdp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ltdp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ltdp_pkg::S_CLEAR;
      start_q     <= 6'd0;
      sp_q        <= 7'd2;
      e1_q        <= ltdp_pkg::NT_BASE;
      clr_q       <= 13'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      e1_q        <= e1_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        start_q <= cfg_start_nonterminal_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    term_q   <= term_d;
    prod_q   <= prod_d;
    k_q      <= k_d;
    exp_q    <= exp_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
    status_q <= status_d;
    expans_q <= expans_d;
  end

endmodule

// ===== test/ll1_table_driven_parser_tb.sv =====
module ll1_table_driven_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000000;
  localparam logic [6:0] T_ID = 7'd10, T_PLUS = 7'd11, T_OPEN = 7'd12, T_CLOSE = 7'd13;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] nt;
    logic [6:0] term;
    logic [7:0] prod;
    logic       ent;
    logic [2:0] slot;
    logic [7:0] sym;
    logic [3:0] len;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] expansions;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_start_nonterminal_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i = '0;
  logic [5:0] nonterminal_index_i = '0;
  logic [6:0] terminal_code_i = '0;
  logic [7:0] production_index_i = '0;
  logic       entry_valid_i = 1'b0;
  logic [2:0] slot_i = '0;
  logic [7:0] symbol_code_i = '0;
  logic [3:0] production_length_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] expansions_o;

  ll1_table_driven_parser DUT (.*);

  initial forever #5 clk_i = ~clk_i;

  // Shadow of the parser state.
  logic [8:0] parse_tbl [ltdp_pkg::NONTERMINALS*ltdp_pkg::TERMINALS];
  logic [7:0] rhs_sym [ltdp_pkg::PRODUCTIONS*ltdp_pkg::MAX_RHS];
  logic [3:0] rhs_len [ltdp_pkg::PRODUCTIONS];
  logic [7:0] sym_stack [ltdp_pkg::STACK_DEPTH];
  int         stack_ptr;
  logic [5:0] start_nt;

  // Tracking that keeps every reachable production fully written.
  logic [7:0] slot_written [ltdp_pkg::PRODUCTIONS];
  bit         len_written [ltdp_pkg::PRODUCTIONS];
  int         tbl_refs [ltdp_pkg::PRODUCTIONS];

  item_t    pending_q [$];
  verdict_t verdict_q [$];
  int       sentence_q [$];
  int       errors = 0;
  bit       in_took = 0, cfg_took = 0;
  int       idle_mode = 0;
  int       hold_req = 0, hold_seen = 0, hold_cnt = 0;
  int       quiet = 0;

  function automatic void reload_stack();
    sym_stack[0] = ltdp_pkg::END_MARK;
    sym_stack[1] = ltdp_pkg::NT_BASE + {2'b00, start_nt};
    stack_ptr = 2;
  endfunction

  function automatic logic [2:0] match_token(input logic [6:0] tok, output int cnt);
    int top, len, p, expd, row;
    logic [8:0] entry;
    expd = 0;
    cnt = 0;
    while (1) begin
      if (stack_ptr == 0 || stack_ptr > ltdp_pkg::STACK_DEPTH) return ltdp_pkg::ST_REJECT;
      top = sym_stack[stack_ptr-1];
      if (top == ltdp_pkg::EMPTY_WORD) begin
        stack_ptr--;
        continue;
      end
      if (top >= ltdp_pkg::NT_BASE) begin
        row = top - ltdp_pkg::NT_BASE;
        if (top >= ltdp_pkg::NT_LIMIT || row >= ltdp_pkg::NONTERMINALS)
          return ltdp_pkg::ST_REJECT;
        entry = parse_tbl[row*ltdp_pkg::TERMINALS + tok];
        if (!entry[8]) return ltdp_pkg::ST_REJECT;
        p = entry[7:0];
        if (expd >= ltdp_pkg::EXPANSION_LIMIT) return ltdp_pkg::ST_REJECT;
        len = rhs_len[p];
        if (len > ltdp_pkg::MAX_RHS) len = ltdp_pkg::MAX_RHS;
        if (stack_ptr - 1 + len > ltdp_pkg::STACK_DEPTH) return ltdp_pkg::ST_OVERFLOW;
        stack_ptr--;
        for (int k = len; k > 0; k--) begin
          sym_stack[stack_ptr] = rhs_sym[p*ltdp_pkg::MAX_RHS + k - 1];
          stack_ptr++;
        end
        expd++;
        if (cnt < 255) cnt++;
        continue;
      end
      if (top != tok) return ltdp_pkg::ST_REJECT;
      if (tok == ltdp_pkg::END_MARK)
        return (stack_ptr == 1) ? ltdp_pkg::ST_ACCEPT : ltdp_pkg::ST_REJECT;
      stack_ptr--;
      return ltdp_pkg::ST_CONSUMED;
    end
    return ltdp_pkg::ST_REJECT;
  endfunction

  function automatic verdict_t parse_item(input item_t it);
    verdict_t v;
    int cnt;
    v.status = ltdp_pkg::ST_LOAD;
    v.expansions = '0;
    case (it.mode)
      ltdp_pkg::MODE_TABLE:
        parse_tbl[it.nt*ltdp_pkg::TERMINALS + it.term] = it.ent ? {1'b1, it.prod} : 9'd0;
      ltdp_pkg::MODE_SYMBOL: begin
        rhs_sym[it.prod*ltdp_pkg::MAX_RHS + it.slot] = it.sym;
        rhs_len[it.prod] = it.len;
      end
      ltdp_pkg::MODE_TOKEN: begin
        v.status = match_token(it.term, cnt);
        v.expansions = 8'(cnt);
        if (v.status != ltdp_pkg::ST_CONSUMED) reload_stack();
      end
      default: reload_stack();
    endcase
    return v;
  endfunction

  function automatic bit rhs_ready(input logic [7:0] mask, input bit lw, input int len);
    if (!lw) return 0;
    if (len > ltdp_pkg::MAX_RHS) len = ltdp_pkg::MAX_RHS;
    for (int k = 0; k < len; k++)
      if (!mask[k]) return 0;
    return 1;
  endfunction

  // Adjusts loads so that no expansion ever reads a production slot never written.
  function automatic item_t make_safe(input item_t it);
    logic [8:0] old;
    logic [7:0] mask;
    int run;
    if (it.mode == ltdp_pkg::MODE_TABLE) begin
      old = parse_tbl[it.nt*ltdp_pkg::TERMINALS + it.term];
      if (it.ent && !rhs_ready(slot_written[it.prod], len_written[it.prod], rhs_len[it.prod]))
        it.ent = 1'b0;
      if (old[8]) tbl_refs[old[7:0]]--;
      if (it.ent) tbl_refs[it.prod]++;
    end else if (it.mode == ltdp_pkg::MODE_SYMBOL) begin
      mask = slot_written[it.prod] | (8'd1 << it.slot);
      if (tbl_refs[it.prod] > 0 && !rhs_ready(mask, 1'b1, it.len)) begin
        run = 0;
        while (run < ltdp_pkg::MAX_RHS && mask[run]) run++;
        it.len = 4'(run);
      end
      slot_written[it.prod] = mask;
      len_written[it.prod] = 1'b1;
    end
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.mode = 2'($urandom_range(0, 3));
    it.nt   = 6'($urandom_range(0, 63));
    it.term = 7'($urandom_range(0, 127));
    it.prod = 8'($urandom_range(0, 255));
    it.ent  = 1'($urandom_range(0, 1));
    it.slot = 3'($urandom_range(0, 7));
    it.sym  = 8'($urandom_range(0, 255));
    it.len  = 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic send(input item_t it);
    it = make_safe(it);
    verdict_q = {verdict_q, parse_item(it)};
    pending_q = {pending_q, it};
  endtask

  task automatic send_token(input int code);
    item_t it;
    it = rand_item();
    it.mode = ltdp_pkg::MODE_TOKEN;
    it.term = 7'(code);
    send(it);
  endtask

  task automatic send_restart();
    item_t it;
    it = rand_item();
    it.mode = ltdp_pkg::MODE_RESTART;
    send(it);
  endtask

  task automatic write_entry(input int nt, input int code, input int p, input bit ent);
    item_t it;
    it = rand_item();
    it.mode = ltdp_pkg::MODE_TABLE;
    it.nt = 6'(nt);
    it.term = 7'(code);
    it.prod = 8'(p);
    it.ent = ent;
    send(it);
  endtask

  task automatic write_rhs(input int p, input int slot, input int sym, input int len);
    item_t it;
    it = rand_item();
    it.mode = ltdp_pkg::MODE_SYMBOL;
    it.prod = 8'(p);
    it.slot = 3'(slot);
    it.sym = 8'(sym);
    it.len = 4'(len);
    send(it);
  endtask

  // Expression grammar E -> T E', E' -> + T E' | empty, T -> ( E ) | id,
  // placed at nonterminals b, b+1, b+2 and productions q..q+4.
  task automatic load_grammar(input int b, input int q);
    write_rhs(q, 0, ltdp_pkg::NT_BASE + b + 2, 2);
    write_rhs(q, 1, ltdp_pkg::NT_BASE + b + 1, 2);
    write_rhs(q+1, 0, T_PLUS, 3);
    write_rhs(q+1, 1, ltdp_pkg::NT_BASE + b + 2, 3);
    write_rhs(q+1, 2, ltdp_pkg::NT_BASE + b + 1, 3);
    write_rhs(q+2, 0, ltdp_pkg::EMPTY_WORD, 1);
    write_rhs(q+3, 0, T_OPEN, 3);
    write_rhs(q+3, 1, ltdp_pkg::NT_BASE + b, 3);
    write_rhs(q+3, 2, T_CLOSE, 3);
    write_rhs(q+4, 0, T_ID, 1);
    write_entry(b, T_ID, q, 1);
    write_entry(b, T_OPEN, q, 1);
    write_entry(b+1, T_PLUS, q+1, 1);
    write_entry(b+1, T_CLOSE, q+2, 1);
    write_entry(b+1, ltdp_pkg::END_MARK, q+2, 1);
    write_entry(b+2, T_OPEN, q+3, 1);
    write_entry(b+2, T_ID, q+4, 1);
  endtask

  task automatic gen_term(input int d, input bit deep);
    if (d > 0 && (deep || $urandom_range(0, 2) == 0)) begin
      sentence_q = {sentence_q, int'(T_OPEN)};
      gen_expr(d - 1, deep);
      sentence_q = {sentence_q, int'(T_CLOSE)};
    end else begin
      sentence_q = {sentence_q, int'(T_ID)};
    end
  endtask

  task automatic gen_expr(input int d, input bit deep);
    int n;
    gen_term(d, deep);
    n = deep ? 0 : $urandom_range(0, 2);
    repeat (n) begin
      sentence_q = {sentence_q, int'(T_PLUS)};
      gen_term(d, deep);
    end
  endtask

  task automatic send_sentence();
    bit deep;
    deep = ($urandom_range(0, 19) == 0);
    sentence_q.delete();
    if (start_nt == 6'd63) gen_term(deep ? 30 : 3, deep);
    else gen_expr(deep ? 30 : 3, deep);
    sentence_q = {sentence_q, int'(ltdp_pkg::END_MARK)};
    if ($urandom_range(0, 9) == 0)
      sentence_q[$urandom_range(0, sentence_q.size() - 1)] = $urandom_range(0, 127);
    if ($urandom_range(0, 19) == 0) void'(sentence_q.pop_back());
    foreach (sentence_q[i]) send_token(sentence_q[i]);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_start(input logic [5:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_start_nonterminal_i = value;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i = 1'b0;
    start_nt = value;
  endtask

  // Sender: a new transaction is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    bit gap;
    item_t it;
    gap = (idle_mode == 1 && $urandom_range(0, 99) < 83) ||
          (idle_mode == 3 && $urandom_range(0, 99) < 6);
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pending_q.size() != 0 && !gap) begin
        it = pending_q.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= it.mode;
        nonterminal_index_i <= it.nt;
        terminal_code_i <= it.term;
        production_index_i <= it.prod;
        entry_valid_i <= it.ent;
        slot_i <= it.slot;
        symbol_code_i <= it.sym;
        production_length_i <= it.len;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready_i <= ($urandom_range(0, 99) >= 83);
    end else if (idle_mode == 3) begin
      out_ready_i <= ($urandom_range(0, 99) >= 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    bit out_took;
    in_took = in_valid_i && in_ready_o;
    cfg_took = cfg_valid_i && cfg_ready_o;
    out_took = out_valid_o && out_ready_i;
    if (out_took) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result status %0d expansions %0d",
                 $time, status_o, expansions_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        if (expansions_o !== want.expansions) begin
          $display("%0t: expansions expected %0d actual %0d",
                   $time, want.expansions, expansions_o);
          errors++;
        end
      end
    end
    if (in_took || cfg_took || out_took || (pending_q.size() == 0 && verdict_q.size() == 0))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("ll1_table_driven_parser_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [5:0] starts [8];
    int n;
    int r;
    starts = '{6'd0, 6'd63, 6'd30, 6'd61, 6'd0, 6'd63, 6'd0, 6'd30};
    starts[6] = 6'($urandom_range(0, 63));
    foreach (parse_tbl[i]) parse_tbl[i] = '0;
    foreach (rhs_sym[i]) rhs_sym[i] = '0;
    foreach (rhs_len[i]) begin
      rhs_len[i] = '0;
      slot_written[i] = '0;
      len_written[i] = 0;
      tbl_refs[i] = 0;
    end
    foreach (sym_stack[i]) sym_stack[i] = '0;
    start_nt = '0;
    reload_stack();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_start(6'd0);

    load_grammar(0, 0);
    load_grammar(61, 5);
    load_grammar(30, 10);
    write_rhs(20, 0, ltdp_pkg::NT_BASE + 40, 1);
    write_rhs(21, 0, ltdp_pkg::NT_BASE + 40, 1);
    write_rhs(22, 0, T_ID, 0);
    for (int k = 0; k < ltdp_pkg::MAX_RHS; k++)
      write_rhs(23, k, (k == 0) ? 7 : ltdp_pkg::EMPTY_WORD, 15);
    write_rhs(24, 0, 200, 1);
    write_rhs(25, 0, ltdp_pkg::NT_BASE + 42, 2);
    write_rhs(25, 1, ltdp_pkg::NT_BASE + 42, 2);
    write_entry(0, 5, 20, 1);
    write_entry(40, 5, 21, 1);
    write_entry(0, 6, 22, 1);
    write_entry(0, 7, 23, 1);
    write_entry(0, 8, 24, 1);
    write_entry(0, 9, 25, 1);
    write_entry(42, 9, 25, 1);

    // Directed sentences and corner tokens.
    send_token(T_ID); send_token(ltdp_pkg::END_MARK);
    send_token(T_OPEN); send_token(T_ID); send_token(T_PLUS); send_token(T_ID);
    send_token(T_CLOSE); send_token(ltdp_pkg::END_MARK);
    send_token(T_ID); send_token(T_ID);
    send_token(T_OPEN); send_token(T_ID); send_token(ltdp_pkg::END_MARK);
    send_token(7); send_token(ltdp_pkg::END_MARK);
    send_token(6);
    send_token(8);
    send_token(9);
    send_token(5);
    send_token(127);
    send_token(ltdp_pkg::EMPTY_WORD);
    send_token(ltdp_pkg::END_MARK);
    write_entry(0, 6, 0, 0);
    send_token(6);
    send_restart();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_start(starts[ph]);
      idle_mode = ph % 4;
      if (ph == 4) hold_req++;
      n = 0;
      while (n < 95) begin
        if (n > 50 && n < 56 && ph == 5) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 2) == 0) begin
            send_restart();
            n++;
          end
          send_sentence();
          n += sentence_q.size();
        end else if (r < 80) begin
          send_token($urandom_range(0, 127));
          n++;
        end else if (r < 88) begin
          write_entry($urandom_range(0, 63), $urandom_range(0, 127),
                      $urandom_range(0, 255), 1'($urandom_range(0, 1)));
          n++;
        end else if (r < 96) begin
          write_rhs($urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 255),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
          n++;
        end else begin
          send_restart();
          n++;
        end
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("ll1_table_driven_parser_tb OK");
    end else begin
      $display("ll1_table_driven_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
